### hdl/acpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_pkg: shared types, constants and functions of the application classifier
// Holds the beat structs, the port and payload signature tables, and the
// combinational helpers used by the front end.
// ----------------------------------------------------------------------------
package acpc_pkg;

  // Input beat: one payload byte with its packet markers and ports.
  typedef struct packed {
    logic        first;
    logic        last;
    logic        has_byte;
    logic [7:0]  data_byte;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } item_t;

  // Result beat: class and how it was found.
  typedef struct packed {
    logic [2:0] app_class;
    logic [1:0] matched_by;
  } result_t;

  // Class codes.
  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_HTTP    = 3'd1;
  localparam logic [2:0] CLS_HTTPS   = 3'd2;
  localparam logic [2:0] CLS_DNS     = 3'd3;
  localparam logic [2:0] CLS_SSH     = 3'd4;
  localparam logic [2:0] CLS_FTP     = 3'd5;

  // Match source codes.
  localparam logic [1:0] MATCH_NONE    = 2'd0;
  localparam logic [1:0] MATCH_PORT    = 2'd1;
  localparam logic [1:0] MATCH_PAYLOAD = 2'd2;

  // Byte history and signature table sizes.
  localparam int HIST_DEPTH   = 5;
  localparam int NUM_PORTS    = 7;
  localparam int NUM_PATTERNS = 8;
  localparam int PAT_MAX_LEN  = 6;
  localparam int NUM_FLAGS    = 4;

  localparam logic [2:0] SEEN_MAX = 3'(HIST_DEPTH);

  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  // Well-known ports, in priority order.
  localparam logic [15:0] PORT_TAB [NUM_PORTS] = '{
    16'd80, 16'd8080, 16'd8000, 16'd443, 16'd53, 16'd22, 16'd21
  };
  localparam logic [2:0] PORT_CLS [NUM_PORTS] = '{
    CLS_HTTP, CLS_HTTP, CLS_HTTP, CLS_HTTPS, CLS_DNS, CLS_SSH, CLS_FTP
  };

  // Payload patterns: length, flag bit and bytes (unused tail is zero).
  localparam logic [2:0] PAT_LEN [NUM_PATTERNS] = '{
    3'd5, 3'd5, 3'd6, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5
  };
  localparam logic [1:0] PAT_FLAG [NUM_PATTERNS] = '{
    2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3
  };
  localparam logic [7:0] PAT_BYTES [NUM_PATTERNS][PAT_MAX_LEN] = '{
    '{8'h47, 8'h45, 8'h54, 8'h20, 8'h2F, 8'h00},  // "GET /"
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00},  // "POST "
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31},  // "HTTP/1"
    '{8'h16, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00},  // TLS record, version 1.0
    '{8'h16, 8'h03, 8'h03, 8'h00, 8'h00, 8'h00},  // TLS record, version 1.2
    '{8'h53, 8'h53, 8'h48, 8'h2D, 8'h32, 8'h00},  // "SSH-2"
    '{8'h32, 8'h32, 8'h30, 8'h20, 8'h00, 8'h00},  // "220 "
    '{8'h55, 8'h53, 8'h45, 8'h52, 8'h20, 8'h00}   // "USER "
  };

  // Class belonging to each payload flag, in priority order.
  localparam logic [2:0] FLAG_CLS [NUM_FLAGS] = '{CLS_HTTP, CLS_HTTPS, CLS_SSH, CLS_FTP};

  // Result queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  // First port entry, in table order, that matches either port.
  function automatic logic [2:0] port_lookup(logic [15:0] sp, logic [15:0] dp);
    logic [2:0] cls;
    cls = CLS_UNKNOWN;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (sp == PORT_TAB[i] || dp == PORT_TAB[i]) begin
        cls = PORT_CLS[i];
      end
    end
    return cls;
  endfunction

  // Flags of every pattern that ends on the current byte.
  function automatic logic [NUM_FLAGS-1:0] pattern_hits(hist_t hist, logic [2:0] seen,
                                                         logic [7:0] cur);
    logic [NUM_FLAGS-1:0] hits;
    logic                 ok;
    int                   n;
    hits = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      n  = int'(PAT_LEN[p]);
      ok = (({1'b0, seen} + 4'd1) >= {1'b0, PAT_LEN[p]}) && (cur == PAT_BYTES[p][n-1]);
      for (int j = 0; j < HIST_DEPTH; j++) begin
        if (j + 1 < n) begin
          ok = ok && (hist[j] == PAT_BYTES[p][n-2-j]);
        end
      end
      if (ok) begin
        hits[PAT_FLAG[p]] = 1'b1;
      end
    end
    return hits;
  endfunction

  // Port class wins; otherwise the first payload flag in priority order.
  function automatic result_t pick_result(logic [2:0] pclass, logic [NUM_FLAGS-1:0] found);
    result_t r;
    r.app_class  = CLS_UNKNOWN;
    r.matched_by = MATCH_NONE;
    if (pclass != CLS_UNKNOWN) begin
      r.app_class  = pclass;
      r.matched_by = MATCH_PORT;
    end else begin
      for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
        if (found[i]) begin
          r.app_class  = FLAG_CLS[i];
          r.matched_by = MATCH_PAYLOAD;
        end
      end
    end
    return r;
  endfunction

endpackage

### hdl/acpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_front: packet tracking front end
// Accepts one beat per cycle while the queue has room, keeps the port class,
// byte history and pattern flags per packet; the last beat pushes a result.
// ----------------------------------------------------------------------------
module acpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  acpc_pkg::item_t   item,
  input  logic              fifo_full,
  output logic              push,
  output acpc_pkg::result_t push_data
);

  acpc_pkg::hist_t                 hist, hist_base, hist_next;
  logic [2:0]                      seen, seen_base, seen_next;
  logic [acpc_pkg::NUM_FLAGS-1:0]  found, found_base, found_next;
  logic [2:0]                      pclass, pclass_next;
  logic                            accept;

  // A beat is taken whenever the queue has room for its possible result.
  assign item_ready = !fifo_full;
  assign accept     = item_valid && item_ready;

  // Packet state after the first marker and the byte of this beat.
  always_comb begin
    hist_base   = hist;
    seen_base   = seen;
    found_base  = found;
    pclass_next = pclass;
    if (item.first) begin
      hist_base   = '0;
      seen_base   = '0;
      found_base  = '0;
      pclass_next = acpc_pkg::port_lookup(item.src_port, item.dst_port);
    end
    hist_next  = hist_base;
    seen_next  = seen_base;
    found_next = found_base;
    if (item.has_byte) begin
      found_next = found_base | acpc_pkg::pattern_hits(hist_base, seen_base, item.data_byte);
      hist_next  = {hist_base[acpc_pkg::HIST_DEPTH-2:0], item.data_byte};
      if (seen_base < acpc_pkg::SEEN_MAX) begin
        seen_next = seen_base + 3'd1;
      end
    end
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist   <= '0;
      seen   <= '0;
      found  <= '0;
      pclass <= acpc_pkg::CLS_UNKNOWN;
    end else if (accept) begin
      hist   <= hist_next;
      seen   <= seen_next;
      found  <= found_next;
      pclass <= pclass_next;
    end
  end

  // The last beat of a packet pushes its verdict.
  assign push      = accept && item.last;
  assign push_data = acpc_pkg::pick_result(pclass_next, found_next);

endmodule

### hdl/acpc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_fifo: result queue
// Short first-in first-out queue that decouples the front end from the
// output stage.
// ----------------------------------------------------------------------------
module acpc_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  acpc_pkg::result_t      push_data,
  input  logic                   pop,
  output acpc_pkg::result_t      rd_data,
  output acpc_pkg::fifo_stat_t   stat
);

  acpc_pkg::result_t                 mem [acpc_pkg::FIFO_DEPTH];
  logic [acpc_pkg::FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [acpc_pkg::FIFO_CNT_W-1:0]   count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data    = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == acpc_pkg::FIFO_CNT_W'(acpc_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule

### hdl/acpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_back: result output stage
// Drains the result queue into the output register and holds each beat until
// the consumer takes it.
// ----------------------------------------------------------------------------
module acpc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  acpc_pkg::fifo_stat_t  stat,
  input  acpc_pkg::result_t     rd_data,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_ready,
  output acpc_pkg::result_t     result
);

  // Refill the output register whenever it is free or being emptied.
  assign pop = !stat.empty && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= rd_data;
    end
  end

endmodule

### hdl/port_and_signature_app_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_and_signature_app_classifier: packet application classifier
// Classifies each packet by well-known ports, or failing that by payload
// signatures seen in a five-byte history, and gives one result per packet.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                    Payload
//  item     in         item_valid / item_ready      acpc_pkg::item_t
//  result   out        result_valid / result_ready  acpc_pkg::result_t
//
// One input beat is taken every cycle unless the queue is full; port lookup
// and pattern compare run in the front end in the cycle the beat is accepted.
// A result is pushed into the result queue when the last beat of its packet
// is accepted, and moves from there into the output register.
// The four-entry result queue sets how long the output may stall before
// item_ready falls; while it is full every input beat waits.
// Reset is synchronous and clears the packet state, the queue and the output.
// ----------------------------------------------------------------------------
module port_and_signature_app_classifier (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  acpc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output acpc_pkg::result_t result
);

  logic                  push;
  logic                  pop;
  acpc_pkg::result_t     push_data;
  acpc_pkg::result_t     rd_data;
  acpc_pkg::fifo_stat_t  stat;

  acpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .fifo_full  (stat.full),
    .push       (push),
    .push_data  (push_data)
  );

  acpc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .stat      (stat)
  );

  acpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .stat         (stat),
    .rd_data      (rd_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A pushed result is in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> !stat.empty)
    else $error("pushed result missing from queue");

  // The front end only stalls when the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> stat.count == acpc_pkg::FIFO_CNT_W'(acpc_pkg::FIFO_DEPTH))
    else $error("input stalled with room in queue");

  // The queue never goes past its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.count <= acpc_pkg::FIFO_CNT_W'(acpc_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // An unmatched result always carries the unknown class.
  a_none_unknown: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.matched_by == acpc_pkg::MATCH_NONE
      |-> result.app_class == acpc_pkg::CLS_UNKNOWN)
    else $error("class given without a match");

endmodule
